// ===== rtl/tbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbc_pkg
// Types and constants shared by the translation block cache modules.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam logic [1:0] KIND_LOOKUP  = 2'd0;
  localparam logic [1:0] KIND_INSTALL = 2'd1;
  localparam logic [1:0] KIND_RANGE   = 2'd2;
  localparam logic [1:0] KIND_ALL     = 2'd3;

  localparam logic       CFG_PHYS_MASK = 1'b0;
  localparam logic       CFG_MAX_BYTES = 1'b1;

  localparam logic [31:0] PHYS_MASK_RESET = 32'd536870911;
  localparam logic [15:0] MAX_BYTES_RESET = 16'd1040;
  localparam logic [31:0] HASH_MULT       = 32'h7feb352d;
  localparam logic [31:0] WORD_BYTES      = 32'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] end_address;
    logic [31:0] entry_address;
    logic [31:0] base_address;
    logic [15:0] code_length;
    logic [9:0]  insn_count;
    logic [31:0] range_size;
    logic        count_stats;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  slot_index;
    logic [31:0] entry_out;
    logic [31:0] base_out;
    logic [31:0] end_out;
    logic [15:0] length_out;
    logic [9:0]  insns_out;
    logic        table_flushed;
    logic [10:0] removed_count;
    logic [31:0] generation_out;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [31:0] entry_addr;
    logic [31:0] base_addr;
    logic [15:0] code_len;
    logic [9:0]  insns;
    logic [31:0] generation;
  } slot_row_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_run;
    logic sweep_start;
    logic sweep_run;
    logic gen_bump;
    logic write_slot;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       scan_done;
    logic       sweep_done;
    logic       want_flush;
    logic       out_free;
  } ctl_sts_t;

endpackage

// ===== rtl/translation_block_cache.sv =====
// ----------------------------------------------------------------------------
// translation_block_cache
// Hashed, linear-probing cache of translated code blocks keyed by start address.
// ----------------------------------------------------------------------------
// One item is taken at a time. The slot memory is read once per cycle. A
// lookup or range invalidation passes through the hash, probe scan, decide and
// result steps, and an install adds a slot write before its result (a range
// invalidation always visits every slot). The result is presented in the same
// cycle that the block can take the next item; a stalled result holds the next
// item in its result step. Invalidate-all bumps the generation and sweeps the
// valid bits, and an install that finds the table full adds a sweep through
// the valid bits. After reset a clearing pass through the valid bits runs
// before the first item is taken; configuration writes are taken throughout.
module translation_block_cache
  import tbc_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  req_t        cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  tbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  tbc_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/tbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbc_ctrl
// Sequencer: hash, probe scan, table sweep, slot write and result transfer.
// ----------------------------------------------------------------------------
module tbc_ctrl
  import tbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t ctl
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HASH   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] ret, ret_next;

  assign cmd_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          ctl.accept = 1'b1;
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        ctl.scan_start = 1'b1;
        if (sts.kind == KIND_ALL) begin
          ctl.gen_bump    = 1'b1;
          ctl.sweep_start = 1'b1;
          ret_next        = ST_RESULT;
          state_next      = ST_SWEEP;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.scan_run = !sts.scan_done;
        if (sts.scan_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.kind == KIND_INSTALL) begin
          if (sts.want_flush) begin
            ctl.gen_bump    = 1'b1;
            ctl.sweep_start = 1'b1;
            ret_next        = ST_WRITE;
            state_next      = ST_SWEEP;
          end else begin
            state_next = ST_WRITE;
          end
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SWEEP: begin
        ctl.sweep_run = !sts.sweep_done;
        if (sts.sweep_done) state_next = ret;
      end
      ST_WRITE: begin
        ctl.write_slot = 1'b1;
        state_next     = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // clear the valid bits after reset before taking any item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

// ===== rtl/tbc_datapath.sv =====
// ----------------------------------------------------------------------------
// tbc_datapath
// Slot memories, hash, probe checks, counters and the result register.
// ----------------------------------------------------------------------------
module tbc_datapath
  import tbc_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024
)(
  input  logic        clk,
  input  logic        rst,
  input  req_t        cmd,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  ctl_cmd_t    ctl,
  output ctl_sts_t    sts,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

  logic             valid_mem [TABLE_SLOTS];
  slot_row_t        data_mem  [TABLE_SLOTS];

  req_t             item;
  logic [31:0]      phys_mask;
  logic [15:0]      max_bytes;
  logic [31:0]      gen;
  logic [31:0]      hits, misses;
  logic [31:0]      prod;
  logic [31:0]      a0, a1;
  logic [CW-1:0]    rd_n;
  logic             chk_live, vld_q;
  slot_row_t        row_q;
  logic [IW-1:0]    chk_idx;
  logic             hit, have, flushed;
  logic [IW-1:0]    pick;
  slot_row_t        hit_row;
  logic [CW-1:0]    removed;

  // hash and written-range bounds
  logic [31:0] hx, hh, size_sel;
  logic [32:0] a1_sum;
  logic [IW-1:0] home;
  always_comb begin
    hx       = item.address >> 2;
    hx       = hx ^ (hx >> 16);
    hh       = prod ^ (prod >> 15);
    home     = hh[IW-1:0];
    size_sel = (item.range_size == 32'd0) ? WORD_BYTES : item.range_size;
    a1_sum   = {1'b0, item.address & phys_mask} + {1'b0, size_sel};
  end

  always_ff @(posedge clk) begin
    prod <= hx * HASH_MULT;
    a0   <= item.address & phys_mask;
    a1   <= a1_sum[32] ? '1 : a1_sum[31:0];
  end

  // probe checks on the registered read data
  logic [31:0] blk_len, len_sel, b0, b1;
  logic [32:0] b1_sum;
  logic        lk_match, in_match, ovl, stop_now, issue;
  logic [IW-1:0] raddr, widx;
  always_comb begin
    lk_match = vld_q && row_q.start_addr == item.address && row_q.generation == gen;
    in_match = vld_q && row_q.start_addr == item.address;
    blk_len  = row_q.end_addr - row_q.start_addr;
    len_sel  = (blk_len == 32'd0 || blk_len > {16'd0, max_bytes}) ? WORD_BYTES : blk_len;
    b0       = row_q.start_addr & phys_mask;
    b1_sum   = {1'b0, b0} + {1'b0, len_sel};
    b1       = b1_sum[32] ? '1 : b1_sum[31:0];
    ovl      = vld_q && a0 < b1 && b0 < a1;
    stop_now = chk_live && !hit &&
               ((item.kind == KIND_LOOKUP && lk_match) ||
                (item.kind == KIND_INSTALL && in_match));
    issue    = ctl.scan_run && rd_n != SLOTS_C && !hit && !stop_now;
    raddr    = (item.kind == KIND_RANGE) ? rd_n[IW-1:0] : IW'(home + rd_n[IW-1:0]);
    widx     = (hit || have) ? pick : home;
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (issue) begin
      vld_q <= valid_mem[raddr];
      row_q <= data_mem[raddr];
    end
    if (ctl.sweep_run) begin
      valid_mem[rd_n[IW-1:0]] <= 1'b0;
    end else if (ctl.write_slot) begin
      valid_mem[widx] <= 1'b1;
    end else if (ctl.scan_run && chk_live && item.kind == KIND_RANGE && ovl) begin
      valid_mem[chk_idx] <= 1'b0;
    end
    if (ctl.write_slot) begin
      data_mem[widx] <= '{start_addr: item.address, end_addr: item.end_address,
                          entry_addr: item.entry_address, base_addr: item.base_address,
                          code_len: item.code_length, insns: item.insn_count,
                          generation: gen};
    end
  end

  // scan and sweep bookkeeping
  always_ff @(posedge clk) begin
    if (ctl.accept) item <= cmd;
    chk_idx <= raddr;
    if (rst) begin
      rd_n     <= '0;
      chk_live <= 1'b0;
      hit      <= 1'b0;
      have     <= 1'b0;
      flushed  <= 1'b0;
      removed  <= '0;
    end else if (ctl.scan_start || ctl.sweep_start) begin
      rd_n     <= '0;
      chk_live <= 1'b0;
      if (ctl.scan_start) begin
        hit     <= 1'b0;
        have    <= 1'b0;
        flushed <= 1'b0;
        removed <= '0;
      end
      if (ctl.gen_bump) flushed <= 1'b1;
    end else if (ctl.sweep_run) begin
      rd_n <= rd_n + 1'b1;
    end else if (ctl.scan_run) begin
      chk_live <= issue;
      if (issue) rd_n <= rd_n + 1'b1;
      if (chk_live && !hit) begin
        unique case (item.kind)
          KIND_LOOKUP: begin
            if (lk_match) begin
              hit     <= 1'b1;
              hit_row <= row_q;
              pick    <= chk_idx;
            end
          end
          KIND_INSTALL: begin
            if (in_match) begin
              hit  <= 1'b1;
              pick <= chk_idx;
            end else if (!vld_q && !have) begin
              have <= 1'b1;
              pick <= chk_idx;
            end
          end
          KIND_RANGE: begin
            if (ovl) removed <= removed + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // configuration, generation and counters
  logic [31:0] gen_inc;
  assign gen_inc = gen + 32'd1;
  always_ff @(posedge clk) begin
    if (rst) begin
      phys_mask <= PHYS_MASK_RESET;
      max_bytes <= MAX_BYTES_RESET;
      gen       <= 32'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PHYS_MASK: phys_mask <= cfg_data;
          CFG_MAX_BYTES: max_bytes <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (ctl.gen_bump) gen <= (gen_inc == 32'd0) ? 32'd1 : gen_inc;
    end
  end

  // result assembly
  logic [31:0] hits_next, misses_next, slot32, rem32;
  rsp_t        res;
  always_comb begin
    hits_next   = hits;
    misses_next = misses;
    if (item.kind == KIND_LOOKUP && item.count_stats) begin
      if (hit) hits_next = hits + 32'd1;
      else     misses_next = misses + 32'd1;
    end
    slot32 = 32'(widx);
    rem32  = 32'(removed);
    res    = '0;
    res.generation_out = gen;
    res.hit_total      = hits_next;
    res.miss_total     = misses_next;
    unique case (item.kind)
      KIND_LOOKUP: begin
        if (hit) begin
          res.found      = 1'b1;
          res.slot_index = slot32[9:0];
          res.entry_out  = hit_row.entry_addr;
          res.base_out   = hit_row.base_addr;
          res.end_out    = hit_row.end_addr;
          res.length_out = hit_row.code_len;
          res.insns_out  = hit_row.insns;
        end
      end
      KIND_INSTALL: begin
        res.found         = 1'b1;
        res.slot_index    = slot32[9:0];
        res.entry_out     = item.entry_address;
        res.base_out      = item.base_address;
        res.end_out       = item.end_address;
        res.length_out    = item.code_length;
        res.insns_out     = item.insn_count;
        res.table_flushed = flushed;
      end
      KIND_RANGE: res.removed_count = rem32[10:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) rsp <= res;
    if (rst) begin
      rsp_valid <= 1'b0;
      hits      <= '0;
      misses    <= '0;
    end else begin
      if (ctl.finish) begin
        rsp_valid <= 1'b1;
        hits      <= hits_next;
        misses    <= misses_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.kind       = item.kind;
    sts.scan_done  = hit || (rd_n == SLOTS_C && !chk_live);
    sts.sweep_done = (rd_n == SLOTS_C);
    sts.want_flush = !hit && !have;
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

`ifndef SYNTHESIS
  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst) gen != 32'd0)
    else $error("generation reached zero");
  a_gen_moves: assert property (@(posedge clk) disable iff (rst)
    ctl.gen_bump |=> gen != $past(gen))
    else $error("generation did not advance on flush");
  a_removed_bound: assert property (@(posedge clk) disable iff (rst) removed <= SLOTS_C)
    else $error("removed count exceeds table size");
  a_no_overlap_ops: assert property (@(posedge clk) disable iff (rst)
    !(ctl.sweep_run && (ctl.scan_run || ctl.write_slot)))
    else $error("sweep overlaps scan or slot write");
`endif

endmodule

// ===== dv/tb_translation_block_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_translation_block_cache
// Self-checking bench for the translation block cache. A behavioural copy of
// the table predicts each response; stimulus mixes directed corner cases with
// random operation streams under several idle and stall profiles.
// ----------------------------------------------------------------------------
module tb_translation_block_cache;
  import tbc_pkg::*;

  localparam int SLOTS = 1024;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  req_t        cmd = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  translation_block_cache dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the table
  logic        t_valid [SLOTS];
  logic [31:0] t_start [SLOTS];
  logic [31:0] t_end   [SLOTS];
  logic [31:0] t_entry [SLOTS];
  logic [31:0] t_base  [SLOTS];
  logic [15:0] t_len   [SLOTS];
  logic [9:0]  t_insns [SLOTS];
  logic [31:0] t_gen   [SLOTS];
  logic [31:0] cur_gen, hits, misses, m_phys;
  logic [15:0] m_maxb;

  rsp_t expected_rsp [$];
  int   errors = 0;
  int   send_idle = 0;
  int   stall_pct = 0;
  bit   hold_off = 1'b0;
  int   n_sent = 0, n_checked = 0, n_hits = 0, n_flushes = 0;

  // known addresses so lookups and installs collide
  logic [31:0] addr_pool [16];

  function automatic logic [9:0] home_of(logic [31:0] a);
    logic [31:0] x;
    x = a >> 2;
    x = x ^ (x >> 16);
    x = x * HASH_MULT;
    x = x ^ (x >> 15);
    return x[9:0];
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) t_valid[i] = 1'b0;
    cur_gen = cur_gen + 32'd1;
    if (cur_gen == 32'd0) cur_gen = 32'd1;
  endfunction

  function automatic void show(ref rsp_t r, input int i);
    r.found = 1'b1;
    r.slot_index = i[9:0];
    r.entry_out = t_entry[i];
    r.base_out = t_base[i];
    r.end_out = t_end[i];
    r.length_out = t_len[i];
    r.insns_out = t_insns[i];
  endfunction

  function automatic rsp_t predict_cache(req_t q);
    rsp_t r;
    logic [9:0] h;
    int i, pick;
    bit have;
    logic [31:0] sz, ln, a0, a1, b0, b1;
    int removed;
    r = '0;
    h = home_of(q.address);
    case (q.kind)
      KIND_LOOKUP: begin
        have = 0;
        for (int n = 0; n < SLOTS && !have; n++) begin
          i = (h + n) % SLOTS;
          if (t_valid[i] && t_start[i] == q.address && t_gen[i] == cur_gen) begin
            have = 1;
            show(r, i);
          end
        end
        if (have) n_hits++;
        if (q.count_stats) begin
          if (have) hits++; else misses++;
        end
      end
      KIND_INSTALL: begin
        have = 0;
        pick = 0;
        for (int n = 0; n < SLOTS; n++) begin
          i = (h + n) % SLOTS;
          if (t_valid[i] && t_start[i] == q.address) begin
            pick = i;
            have = 1;
            break;
          end
          if (!t_valid[i] && !have) begin
            pick = i;
            have = 1;
          end
        end
        if (!have) begin
          clear_table();
          pick = h;
          r.table_flushed = 1'b1;
          n_flushes++;
        end
        t_start[pick] = q.address;
        t_end[pick] = q.end_address;
        t_entry[pick] = q.entry_address;
        t_base[pick] = q.base_address;
        t_len[pick] = q.code_length;
        t_insns[pick] = q.insn_count;
        t_gen[pick] = cur_gen;
        t_valid[pick] = 1'b1;
        show(r, pick);
      end
      KIND_RANGE: begin
        sz = (q.range_size == 32'd0) ? 32'd4 : q.range_size;
        removed = 0;
        a0 = q.address & m_phys;
        a1 = sat_sum(a0, sz);
        for (int k = 0; k < SLOTS; k++) begin
          if (t_valid[k]) begin
            ln = t_end[k] - t_start[k];
            if (ln == 32'd0 || ln > {16'd0, m_maxb}) ln = 32'd4;
            b0 = t_start[k] & m_phys;
            b1 = sat_sum(b0, ln);
            if (a0 < b1 && b0 < a1) begin
              t_valid[k] = 1'b0;
              removed++;
            end
          end
        end
        r.removed_count = removed[10:0];
      end
      default: clear_table();
    endcase
    r.generation_out = cur_gen;
    r.hit_total = hits;
    r.miss_total = misses;
    return r;
  endfunction

  task automatic send_op(req_t q);
    int gap;
    if (send_idle > 0) begin
      gap = 0;
      while ($urandom_range(99) < send_idle) gap++;
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd <= q;
    cmd_valid <= 1'b1;
    expected_rsp.push_back(predict_cache(q));
    n_sent++;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PHYS_MASK) m_phys = v; else m_maxb = v[15:0];
  endtask

  function automatic req_t rand_op(int w_lookup, int w_install, int w_range);
    req_t q;
    int p;
    q.entry_address = $urandom();
    q.base_address = $urandom();
    q.code_length = 16'($urandom());
    q.insn_count = 10'($urandom());
    q.count_stats = 1'($urandom_range(1));
    q.address = ($urandom_range(3) != 0) ? addr_pool[$urandom_range(15)] : $urandom();
    q.end_address = ($urandom_range(3) != 0) ? q.address + $urandom_range(2000) : $urandom();
    q.range_size = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(64);
    p = $urandom_range(w_lookup + w_install + w_range);
    if (p < w_lookup) q.kind = KIND_LOOKUP;
    else if (p < w_lookup + w_install) q.kind = KIND_INSTALL;
    else if (p < w_lookup + w_install + w_range) q.kind = KIND_RANGE;
    else q.kind = KIND_ALL;
    return q;
  endfunction

  function automatic req_t mk(logic [1:0] k, logic [31:0] a, logic [31:0] e,
                              logic [31:0] sz);
    req_t q;
    q = '0;
    q.kind = k;
    q.address = a;
    q.end_address = e;
    q.range_size = sz;
    q.entry_address = ~a;
    q.base_address = a ^ 32'h5A5A_5A5A;
    q.code_length = a[15:0];
    q.insn_count = a[9:0];
    q.count_stats = 1'b1;
    return q;
  endfunction

  // Check every response against the oldest prediction
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response %h", $time, rsp);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        n_checked++;
        if (rsp !== e) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, rsp);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random, or held for a long stretch on request
  always @(posedge clk) begin
    if (hold_off) rsp_stall <= 1'b1;
    else rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic test_directed();
    req_t q;
    q = mk(KIND_LOOKUP, 32'h0, 32'h0, 32'h0);
    q.count_stats = 1'b0;
    send_op(q);
    send_op(mk(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_op(mk(KIND_INSTALL, 32'h0000_1000, 32'h0000_1040, 32'h0));
    send_op(mk(KIND_INSTALL, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'h0));  // zero span
    send_op(mk(KIND_INSTALL, 32'h8000_0000, 32'h8001_0000, 32'h0));  // too long
    send_op(mk(KIND_LOOKUP, 32'h0000_1000, 32'h0, 32'h0));
    send_op(mk(KIND_INSTALL, 32'h0000_1000, 32'h0000_1010, 32'h0));  // overwrite
    send_op(mk(KIND_LOOKUP, 32'h0000_1000, 32'h0, 32'h0));
    send_op(mk(KIND_RANGE, 32'h0000_100C, 32'h0, 32'h0));            // zero size, taken as one word
    send_op(mk(KIND_LOOKUP, 32'h0000_1000, 32'h0, 32'h0));
    send_op(mk(KIND_RANGE, 32'hFFFF_FFF0, 32'h0, 32'hFFFF_FFFF));    // saturate
    q = mk(KIND_INSTALL, 32'h0000_2000, 32'h0000_2008, 32'h0);
    q.entry_address = '1; q.base_address = '1; q.code_length = '1; q.insn_count = '1;
    send_op(q);
    send_op(mk(KIND_ALL, 32'h0, 32'h0, 32'h0));
    send_op(mk(KIND_LOOKUP, 32'h0000_2000, 32'h0, 32'h0));           // stale generation
    send_op(mk(KIND_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFF));
  endtask

  task automatic test_config_extremes();
    go_idle();
    write_reg(CFG_PHYS_MASK, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_BYTES, 32'h0000_FFFF);
    for (int i = 0; i < 40; i++) send_op(rand_op(30, 40, 25));
    go_idle();
    write_reg(CFG_PHYS_MASK, 32'h0);
    write_reg(CFG_MAX_BYTES, 32'd4);
    for (int i = 0; i < 40; i++) send_op(rand_op(30, 40, 25));
    go_idle();
    write_reg(CFG_PHYS_MASK, PHYS_MASK_RESET);
    write_reg(CFG_MAX_BYTES, {16'd0, MAX_BYTES_RESET});
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    send_idle = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_op(rand_op(45, 40, 12));
    go_idle();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_op(rand_op(50, 40, 5));
    join
    go_idle();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      t_valid[i] = 0; t_start[i] = 0; t_end[i] = 0; t_entry[i] = 0;
      t_base[i] = 0; t_len[i] = 0; t_insns[i] = 0; t_gen[i] = 0;
    end
    cur_gen = 1; hits = 0; misses = 0;
    m_phys = PHYS_MASK_RESET; m_maxb = MAX_BYTES_RESET;
    for (int i = 0; i < 16; i++) addr_pool[i] = $urandom() & 32'hFFFF_FFFC;
    addr_pool[15] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_random_phase(150, 0, 0);
    test_random_phase(110, 74, 0);
    test_random_phase(110, 0, 74);
    test_random_phase(110, 10, 10);
    test_backpressure();
    go_idle();
    repeat (2100) @(posedge clk);
    $display("Ran %0d operations, %0d responses checked, %0d lookup hits, %0d flushes",
             n_sent, n_checked, n_hits, n_flushes);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== translation_block_cache.f =====
rtl/tbc_pkg.sv
rtl/tbc_ctrl.sv
rtl/tbc_datapath.sv
rtl/translation_block_cache.sv
dv/tb_translation_block_cache.sv
